// ===== src/assert_macros.svh =====
// Assertion helpers: clocked property checks with an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge out of reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition never occurs at a rising clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif
`endif

// ===== src/lcb_pkg.sv =====
`default_nettype none
package lcb_pkg;

  // Number of path points, one cell each.
  localparam int POINTS = 64;
  localparam int IDXW   = $clog2(POINTS);
  // Common width for comparing a 6-bit point index against a cell position.
  localparam int CMPW   = (IDXW > 6) ? IDXW : 6;
  // Edge positions: 20-bit station plus or minus a 15-bit half length, signed.
  localparam int EDGEW  = 22;

  localparam logic [14:0] HALF_LENGTH_RESET = 15'd640;
  localparam logic [14:0] HALF_WIDTH_RESET  = 15'd256;
  localparam logic [14:0] BOUND_LIMIT_RESET = 15'd2048;
  localparam logic signed [15:0] BOUND_RESET = 16'sd2048;

  // Command codes on cmd_i.
  typedef enum logic [1:0] {
    CMD_WRITE_POINT    = 2'd0,
    CMD_APPLY_OBSTACLE = 2'd1,
    CMD_READ_BOUNDS    = 2'd2,
    CMD_CLEAR_BOUNDS   = 2'd3
  } corridor_cmd_e;

  // Configuration register indexes on cfg_index_i.
  localparam logic [1:0] REG_HALF_LENGTH = 2'd0;
  localparam logic [1:0] REG_HALF_WIDTH  = 2'd1;
  localparam logic [1:0] REG_BOUND_LIMIT = 2'd2;

  // Kind of pass a packet makes through the cell chain.
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_SEARCH,
    OP_APPLY,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LOWER = 2'd1,
    SIDE_UPPER = 2'd2
  } side_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_PICK,
    ST_APPLY
  } state_e;

  // Running nearest-point search for one edge.
  typedef struct packed {
    logic                   found;
    logic                   f0;
    logic [IDXW-1:0]        res;
    logic signed [15:0]     lat;
  } srch_t;

  // Packet handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic                    valid;
    op_e                     op;
    logic [IDXW-1:0]         pos;
    logic [5:0]              idx;
    logic [19:0]             station;
    logic signed [15:0]      lateral;
    logic signed [EDGEW-1:0] edge_r;
    logic signed [EDGEW-1:0] edge_f;
    srch_t                   srch_r;
    srch_t                   srch_f;
    logic [19:0]             prev_station;
    logic signed [15:0]      prev_lateral;
    logic [IDXW-1:0]         s_idx;
    logic [IDXW-1:0]         e_idx;
    side_e                   side;
    logic signed [15:0]      bound;
    logic signed [15:0]      lo;
    logic signed [15:0]      up;
  } pkt_t;

endpackage
`default_nettype wire

// ===== src/lcb_cell.sv =====
`default_nettype none
module lcb_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lcb_pkg::pkt_t pkt_i,
  output lcb_pkg::pkt_t      pkt_o
);
  import lcb_pkg::*;

  logic [19:0]        station_q;
  logic signed [15:0] lateral_q;
  logic signed [15:0] lower_q, lower_d;
  logic signed [15:0] upper_q, upper_d;
  logic               wr_en;
  logic               hit;
  logic               in_range;
  pkt_t               pkt_d, pkt_q;

  // One step of the nearest-point search at this cell.
  function automatic srch_t search_step(srch_t s, logic signed [EDGEW-1:0] e,
                                        logic [IDXW-1:0] pos, logic [19:0] st,
                                        logic signed [15:0] lat, logic [19:0] pst,
                                        logic signed [15:0] plat);
    srch_t                 r;
    logic signed [EDGEW:0] d_here;
    logic signed [EDGEW:0] d_prev;
    logic                  reached;
    r       = s;
    reached = $signed({2'b00, st}) >= e;
    d_here  = $signed({3'b000, st}) - $signed({e[EDGEW-1], e});
    d_prev  = $signed({e[EDGEW-1], e}) - $signed({3'b000, pst});
    if (!s.found && reached) begin
      r.found = 1'b1;
      if (pos == '0) begin
        r.f0  = 1'b1;
        r.res = '0;
        r.lat = lat;
      end else if (d_here > d_prev) begin
        r.res = pos - IDXW'(1);
        r.lat = plat;
      end else begin
        r.res = pos;
        r.lat = lat;
      end
    end
    return r;
  endfunction

  // Act on the passing packet and hand it on.
  always_comb begin
    pkt_d              = pkt_i;
    pkt_d.pos          = pkt_i.pos + IDXW'(1);
    pkt_d.prev_station = station_q;
    pkt_d.prev_lateral = lateral_q;
    lower_d            = lower_q;
    upper_d            = upper_q;
    wr_en              = 1'b0;
    hit                = CMPW'(pkt_i.idx) == CMPW'(pkt_i.pos);
    in_range           = (pkt_i.pos >= pkt_i.s_idx) && (pkt_i.pos <= pkt_i.e_idx);
    if (pkt_i.valid) begin
      unique case (pkt_i.op)
        OP_WRITE: begin
          wr_en = hit;
        end
        OP_SEARCH: begin
          pkt_d.srch_r = search_step(pkt_i.srch_r, pkt_i.edge_r, pkt_i.pos, station_q,
                                     lateral_q, pkt_i.prev_station, pkt_i.prev_lateral);
          pkt_d.srch_f = search_step(pkt_i.srch_f, pkt_i.edge_f, pkt_i.pos, station_q,
                                     lateral_q, pkt_i.prev_station, pkt_i.prev_lateral);
        end
        OP_APPLY: begin
          if (in_range) begin
            if (pkt_i.side == SIDE_LOWER) begin
              if ($signed(lower_q) < $signed(pkt_i.bound)) lower_d = pkt_i.bound;
            end else if (pkt_i.side == SIDE_UPPER) begin
              if ($signed(upper_q) > $signed(pkt_i.bound)) upper_d = pkt_i.bound;
            end
          end
        end
        OP_READ: begin
          if (hit) begin
            pkt_d.lo = lower_q;
            pkt_d.up = upper_q;
          end
        end
        OP_CLEAR: begin
          lower_d = -$signed(pkt_i.bound);
          upper_d = pkt_i.bound;
        end
        default: ;
      endcase
    end
  end

  // Advance the packet and hold the bounds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q   <= '0;
      lower_q <= -BOUND_RESET;
      upper_q <= BOUND_RESET;
    end else begin
      pkt_q   <= pkt_d;
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

  // Store the path point.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      station_q <= pkt_i.station;
      lateral_q <= pkt_i.lateral;
    end
  end

  assign pkt_o = pkt_q;

endmodule
`default_nettype wire

// ===== src/lcb_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module lcb_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [5:0]  point_index_i,
  input  wire logic [19:0] station_i,
  input  wire logic signed [15:0] lateral_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i,
  output lcb_pkg::pkt_t    launch_o,
  input  wire lcb_pkg::pkt_t exit_i,
  output logic             done_o,
  output logic [5:0]       start_point_o,
  output logic [5:0]       end_point_o,
  output logic [1:0]       obstacle_side_o,
  output logic signed [15:0] lower_bound_o,
  output logic signed [15:0] upper_bound_o
);
  import lcb_pkg::*;

  state_e             state_q, state_d;
  logic [14:0]        half_len_q, half_wid_q, bound_lim_q;
  pkt_t               launch_q, launch_d;
  logic [IDXW-1:0]    s_q, s_d, e_q, e_d;
  logic signed [15:0] lat_s_q, lat_s_d, lat_e_q, lat_e_d;
  logic signed [15:0] ob_lat_q, ob_lat_d;
  logic               done_q, done_d;
  logic [5:0]         res_sp_q, res_sp_d, res_ep_q, res_ep_d;
  side_e              res_side_q, res_side_d;
  logic signed [15:0] res_lo_q, res_lo_d, res_up_q, res_up_d;
  logic               accept;
  logic               skip;
  srch_t              fin_r, fin_f;
  logic signed [16:0] lat_sum;
  logic signed [16:0] lat_twice;
  logic signed [17:0] raise_val, lower_val;

  function automatic logic signed [15:0] sat16(logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Close a search: the last point wins when the edge lies at or past it.
  function automatic srch_t finish_search(srch_t s, logic signed [EDGEW-1:0] e,
                                          logic [19:0] st_last,
                                          logic signed [15:0] lat_last);
    srch_t r;
    r = s;
    if (!s.f0 && ($signed({2'b00, st_last}) <= e)) begin
      r.res = IDXW'(POINTS - 1);
      r.lat = lat_last;
    end
    return r;
  endfunction

  assign accept      = start && !busy;
  assign busy        = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign skip        = (s_q == '0) && (e_q == '0);
  assign fin_r       = finish_search(exit_i.srch_r, exit_i.edge_r, exit_i.prev_station,
                                     exit_i.prev_lateral);
  assign fin_f       = finish_search(exit_i.srch_f, exit_i.edge_f, exit_i.prev_station,
                                     exit_i.prev_lateral);
  assign lat_sum     = $signed({lat_s_q[15], lat_s_q}) + $signed({lat_e_q[15], lat_e_q});
  assign lat_twice   = $signed({ob_lat_q, 1'b0});
  assign raise_val   = $signed({{2{ob_lat_q[15]}}, ob_lat_q}) + $signed({3'b000, half_wid_q});
  assign lower_val   = $signed({{2{ob_lat_q[15]}}, ob_lat_q}) - $signed({3'b000, half_wid_q});

  // Hold the configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_len_q  <= HALF_LENGTH_RESET;
      half_wid_q  <= HALF_WIDTH_RESET;
      bound_lim_q <= BOUND_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HALF_LENGTH: half_len_q  <= cfg_data_i;
        REG_HALF_WIDTH:  half_wid_q  <= cfg_data_i;
        REG_BOUND_LIMIT: bound_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_PASS;
      ST_PASS: begin
        if (exit_i.valid) state_d = (exit_i.op == OP_SEARCH) ? ST_PICK : ST_IDLE;
      end
      ST_PICK:  state_d = skip ? ST_IDLE : ST_APPLY;
      ST_APPLY: if (exit_i.valid) state_d = ST_IDLE;
    endcase
  end

  // Launch packets, collect search results and build the result.
  always_comb begin
    launch_d   = '0;
    done_d     = 1'b0;
    s_d        = s_q;
    e_d        = e_q;
    lat_s_d    = lat_s_q;
    lat_e_d    = lat_e_q;
    ob_lat_d   = ob_lat_q;
    res_sp_d   = res_sp_q;
    res_ep_d   = res_ep_q;
    res_side_d = res_side_q;
    res_lo_d   = res_lo_q;
    res_up_d   = res_up_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ob_lat_d         = lateral_i;
          res_sp_d         = '0;
          res_ep_d         = '0;
          res_side_d       = SIDE_NONE;
          res_lo_d         = '0;
          res_up_d         = '0;
          launch_d.valid   = 1'b1;
          launch_d.idx     = point_index_i;
          launch_d.station = station_i;
          launch_d.lateral = lateral_i;
          launch_d.edge_r  = $signed({2'b00, station_i}) - $signed({7'd0, half_len_q});
          launch_d.edge_f  = $signed({2'b00, station_i}) + $signed({7'd0, half_len_q});
          launch_d.bound   = $signed({1'b0, bound_lim_q});
          unique case (cmd_i)
            CMD_WRITE_POINT:    launch_d.op = OP_WRITE;
            CMD_APPLY_OBSTACLE: launch_d.op = OP_SEARCH;
            CMD_READ_BOUNDS:    launch_d.op = OP_READ;
            CMD_CLEAR_BOUNDS:   launch_d.op = OP_CLEAR;
          endcase
        end
      end
      ST_PASS: begin
        if (exit_i.valid) begin
          if (exit_i.op == OP_SEARCH) begin
            s_d      = fin_r.res;
            e_d      = fin_f.res;
            lat_s_d  = fin_r.lat;
            lat_e_d  = fin_f.lat;
            res_sp_d = 6'(fin_r.res);
            res_ep_d = 6'(fin_f.res);
          end else begin
            res_lo_d = exit_i.lo;
            res_up_d = exit_i.up;
            done_d   = 1'b1;
          end
        end
      end
      ST_PICK: begin
        if (skip) begin
          done_d = 1'b1;
        end else begin
          launch_d.valid = 1'b1;
          launch_d.op    = OP_APPLY;
          launch_d.s_idx = s_q;
          launch_d.e_idx = e_q;
          if (lat_sum > lat_twice) begin
            launch_d.side  = SIDE_LOWER;
            launch_d.bound = sat16(raise_val);
            res_side_d     = SIDE_LOWER;
          end else begin
            launch_d.side  = SIDE_UPPER;
            launch_d.bound = sat16(lower_val);
            res_side_d     = SIDE_UPPER;
          end
        end
      end
      ST_APPLY: begin
        if (exit_i.valid) done_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      launch_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q        <= s_d;
    e_q        <= e_d;
    lat_s_q    <= lat_s_d;
    lat_e_q    <= lat_e_d;
    ob_lat_q   <= ob_lat_d;
    res_sp_q   <= res_sp_d;
    res_ep_q   <= res_ep_d;
    res_side_q <= res_side_d;
    res_lo_q   <= res_lo_d;
    res_up_q   <= res_up_d;
  end

  assign launch_o        = launch_q;
  assign done_o          = done_q;
  assign start_point_o   = res_sp_q;
  assign end_point_o     = res_ep_q;
  assign obstacle_side_o = res_side_q;
  assign lower_bound_o   = res_lo_q;
  assign upper_bound_o   = res_up_q;

  `ASSERT_AT(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "result strobe while busy")
  `ASSERT_AT(a_launch_after_accept, clk_i, rst_ni, accept |=> launch_q.valid, "no launch")
  `ASSERT_AT(a_launch_single, clk_i, rst_ni, launch_q.valid |=> !launch_q.valid, "long launch")
  `ASSERT_NEVER(a_exit_unexpected, clk_i, rst_ni, exit_i.valid && !(state_q == ST_PASS || state_q == ST_APPLY), "packet left chain while not waiting")
  `ASSERT_AT(a_pick_after_pass, clk_i, rst_ni, (state_q == ST_PICK) |-> ($past(state_q) == ST_PASS), "pick entered without search pass")

endmodule
`default_nettype wire

// ===== src/lateral_corridor_bounds_unit.sv =====
// The result strobe is registered after the packet leaves the chain for write, read and
// clear, after the pick step for a skipped obstacle, and after the update pass otherwise.
// One command at a time; a packet crosses the chain of POINTS cells at one cell a cycle,
// an obstacle needs a search pass and, unless both end points are zero, an update pass.
// The result strobe lasts one cycle and cannot be stalled; busy is low during it.
// Reset: asynchronous, active low; bounds return to -/+2048, configuration to defaults.
`default_nettype none
module lateral_corridor_bounds_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [5:0]  point_index_i,
  input  wire logic [19:0] station_i,
  input  wire logic signed [15:0] lateral_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i,
  output logic             done_o,
  output logic [5:0]       start_point_o,
  output logic [5:0]       end_point_o,
  output logic [1:0]       obstacle_side_o,
  output logic signed [15:0] lower_bound_o,
  output logic signed [15:0] upper_bound_o
);
  import lcb_pkg::*;

  // Packet at the input of each cell; the last entry leaves the chain.
  pkt_t chain [POINTS+1];

  lcb_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .point_index_i   (point_index_i),
    .station_i       (station_i),
    .lateral_i       (lateral_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .launch_o        (chain[0]),
    .exit_i          (chain[POINTS]),
    .done_o          (done_o),
    .start_point_o   (start_point_o),
    .end_point_o     (end_point_o),
    .obstacle_side_o (obstacle_side_o),
    .lower_bound_o   (lower_bound_o),
    .upper_bound_o   (upper_bound_o)
  );

  // Build the row of point cells.
  for (genvar i = 0; i < POINTS; i++) begin : g_cell
    lcb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pkt_i  (chain[i]),
      .pkt_o  (chain[i+1])
    );
  end

endmodule
`default_nettype wire
